/* rtl/core/dsa_pkg.sv */
// Shared types and constants for the descriptor slot allocator.
package dsa_pkg;

  localparam int ADDR_W    = 64;
  localparam int CNT_W     = 11;
  localparam int STRIDE_W  = 9;
  localparam int SLOT_W    = 10;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  // quotient bits retired per divider cycle
  localparam int DIV_BITS  = 4;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_PROCESS = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_ALIGN   = 3'd4,
    STAT_NULL    = 3'd5,
    STAT_PENDING = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT  = 3'd0,
    REG_SLOT_STRIDE = 3'd1,
    REG_CPU_BASE    = 3'd2,
    REG_GPU_BASE    = 3'd3,
    REG_GPU_VISIBLE = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_MUL,
    ST_ALLOC_ADD,
    ST_FREE_CHK,
    ST_FREE_DIV,
    ST_PROC_RD,
    ST_PROC_WR,
    ST_EMIT
  } state_t;

endpackage

/* rtl/core/dsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dsa_ram
  import dsa_pkg::*;
#(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/dsa_div.sv */
// Radix-2 restoring divider, DIV_BITS quotient bits per cycle, narrow divisor.
module dsa_div
  import dsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ADDR_W-1:0]   dividend,
  input  logic [STRIDE_W-1:0] divisor,
  output logic                done,
  output logic [ADDR_W-1:0]   quotient,
  output logic [STRIDE_W-1:0] remainder
);

  localparam int DIV_STEPS = ADDR_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  logic                busy;
  logic [STEP_W-1:0]   step;
  // dividend bits shift out the top, quotient bits shift in at the bottom
  logic [ADDR_W-1:0]   work;
  logic [STRIDE_W-1:0] rem;

  logic [ADDR_W-1:0]   work_next;
  logic [STRIDE_W-1:0] rem_next;
  logic [STRIDE_W:0]   trial;

  always_comb begin
    rem_next  = rem;
    work_next = work;
    trial     = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial     = {rem_next, work_next[ADDR_W-1]};
      work_next = {work_next[ADDR_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next     = STRIDE_W'(trial - {1'b0, divisor});
        work_next[0] = 1'b1;
      end else begin
        rem_next = trial[STRIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

/* rtl/core/descriptor_slot_allocator_top.sv */
// Slot allocator: free-index stack and deferred-free queue, both in RAM.
// Allocate runs read, multiply and add states before the result; free runs a 64-bit
// divide by stride, 4 quotient bits per cycle; process alternates a queue read and a
// stack write per queued free. Early errors and op 3 go straight to the emit state.
// One beat in flight; the next beat is taken once the result sits in the output reg.
// Sync reset clears counters and sets config to its defaults; stack identity order comes from a watermark.
module descriptor_slot_allocator_top
  import dsa_pkg::*;
#(
  parameter int POOL_SIZE = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [ADDR_W-1:0]    release_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    cpu_address,
  output logic [ADDR_W-1:0]    gpu_address,
  output logic [SLOT_W-1:0]    slot_index,
  output logic [STATUS_W-1:0]  status
);

  localparam int AW     = $clog2(POOL_SIZE);
  localparam int PROD_W = AW + STRIDE_W;

  // configuration
  logic [CNT_W-1:0]    slot_count;
  logic [STRIDE_W-1:0] slot_stride;
  logic [ADDR_W-1:0]   cpu_base;
  logic [ADDR_W-1:0]   gpu_base;
  logic                gpu_visible;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= CNT_W'(1024);
      slot_stride <= STRIDE_W'(32);
      cpu_base    <= '0;
      gpu_base    <= '0;
      gpu_visible <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLOT_COUNT:  slot_count  <= cfg_data[CNT_W-1:0];
        REG_SLOT_STRIDE: slot_stride <= cfg_data[STRIDE_W-1:0];
        REG_CPU_BASE:    cpu_base    <= cfg_data;
        REG_GPU_BASE:    gpu_base    <= cfg_data;
        REG_GPU_VISIBLE: gpu_visible <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0]    cap;
  logic [STRIDE_W-1:0] stride_eff;

  assign cap = (32'(slot_count) > 32'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : slot_count;
  assign stride_eff = (slot_stride == '0) ? STRIDE_W'(1) : slot_stride;

  // control and datapath registers
  state_t              state, state_next;
  logic [CNT_W-1:0]    alloc_count, alloc_count_next;
  // stack positions at or above the watermark were never written: they hold identity
  logic [CNT_W-1:0]    hwm, hwm_next;
  logic [CNT_W-1:0]    pend_count, pend_count_next;
  logic [CNT_W-1:0]    drain_idx, drain_idx_next;
  logic [ADDR_W-1:0]   req_addr, req_addr_next;
  logic                fresh, fresh_next;
  logic [PROD_W-1:0]   prod, prod_next;
  logic [ADDR_W-1:0]   res_cpu, res_cpu_next;
  logic [ADDR_W-1:0]   res_gpu, res_gpu_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  status_t             res_status, res_status_next;

  // memory ports
  logic                stack_we;
  logic [AW-1:0]       stack_waddr, stack_raddr;
  logic [AW-1:0]       stack_wdata, stack_rdata;
  logic                pend_we;
  logic [AW-1:0]       pend_waddr, pend_raddr;
  logic [AW-1:0]       pend_wdata, pend_rdata;

  // divider
  logic                div_start, div_done;
  logic [ADDR_W-1:0]   div_quo;
  logic [STRIDE_W-1:0] div_rem;
  logic [ADDR_W:0]     diff;
  logic                out_load;
  logic [AW-1:0]       alloc_idx;

  assign diff      = {1'b0, req_addr} - {1'b0, cpu_base};
  assign alloc_idx = fresh ? AW'(alloc_count) : stack_rdata;

  dsa_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  dsa_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  dsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (diff[ADDR_W-1:0]),
    .divisor   (stride_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_stall = rst || (state != ST_IDLE);

  // The FSM handles one beat at a time, so a RAM write always completes before any
  // later read of the same entry: no forwarding needed.
  always_comb begin
    state_next       = state;
    alloc_count_next = alloc_count;
    hwm_next         = hwm;
    pend_count_next  = pend_count;
    drain_idx_next   = drain_idx;
    req_addr_next    = req_addr;
    fresh_next       = fresh;
    prod_next        = prod;
    res_cpu_next     = res_cpu;
    res_gpu_next     = res_gpu;
    res_slot_next    = res_slot;
    res_status_next  = res_status;
    stack_we         = 1'b0;
    stack_waddr      = AW'(alloc_count - CNT_W'(1));
    stack_wdata      = pend_rdata;
    stack_raddr      = AW'(alloc_count);
    pend_we          = 1'b0;
    pend_waddr       = AW'(pend_count);
    pend_wdata       = AW'(div_quo);
    pend_raddr       = AW'(drain_idx);
    div_start        = 1'b0;
    out_load         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_addr_next   = release_address;
          res_cpu_next    = '0;
          res_gpu_next    = '0;
          res_slot_next   = '0;
          res_status_next = STAT_OK;
          unique case (op_t'(opcode))
            OP_ALLOC:   state_next = ST_ALLOC_RD;
            OP_FREE:    state_next = ST_FREE_CHK;
            OP_PROCESS: begin
              drain_idx_next = '0;
              state_next     = ST_PROC_RD;
            end
            OP_NOP:     state_next = ST_EMIT;
            default:    state_next = ST_EMIT;
          endcase
        end
      end

      ST_ALLOC_RD: begin
        if (alloc_count >= cap) begin
          res_status_next = STAT_FULL;
          state_next      = ST_EMIT;
        end else begin
          fresh_next = (alloc_count >= hwm);
          state_next = ST_ALLOC_MUL;
        end
      end

      ST_ALLOC_MUL: begin
        prod_next     = PROD_W'(alloc_idx) * PROD_W'(stride_eff);
        res_slot_next = SLOT_W'(alloc_idx);
        state_next    = ST_ALLOC_ADD;
      end

      ST_ALLOC_ADD: begin
        res_cpu_next     = cpu_base + ADDR_W'(prod);
        res_gpu_next     = gpu_visible ? gpu_base + ADDR_W'(prod) : '0;
        alloc_count_next = alloc_count + CNT_W'(1);
        if (alloc_count_next > hwm) begin
          hwm_next = alloc_count_next;
        end
        state_next = ST_EMIT;
      end

      ST_FREE_CHK: begin
        priority if (req_addr == '0) begin
          res_status_next = STAT_NULL;
          state_next      = ST_EMIT;
        end else if (alloc_count == '0) begin
          res_status_next = STAT_EMPTY;
          state_next      = ST_EMIT;
        end else if (diff[ADDR_W]) begin
          res_status_next = STAT_RANGE;
          state_next      = ST_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_FREE_DIV;
        end
      end

      ST_FREE_DIV: begin
        if (div_done) begin
          priority if (div_rem != '0) begin
            res_status_next = STAT_ALIGN;
          end else if (div_quo >= ADDR_W'(cap)) begin
            res_status_next = STAT_RANGE;
          end else if (pend_count >= alloc_count ||
                       32'(pend_count) >= 32'(POOL_SIZE)) begin
            res_status_next = STAT_PENDING;
          end else begin
            pend_we         = 1'b1;
            pend_count_next = pend_count + CNT_W'(1);
            res_slot_next   = SLOT_W'(div_quo);
          end
          state_next = ST_EMIT;
        end
      end

      ST_PROC_RD: begin
        if (drain_idx >= pend_count || alloc_count == '0) begin
          // whatever is still queued is dropped once the stack is full again
          pend_count_next = '0;
          state_next      = ST_EMIT;
        end else begin
          drain_idx_next = drain_idx + CNT_W'(1);
          state_next     = ST_PROC_WR;
        end
      end

      ST_PROC_WR: begin
        stack_we         = 1'b1;
        alloc_count_next = alloc_count - CNT_W'(1);
        state_next       = ST_PROC_RD;
      end

      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      alloc_count <= '0;
      hwm         <= '0;
      pend_count  <= '0;
      drain_idx   <= '0;
    end else begin
      state       <= state_next;
      alloc_count <= alloc_count_next;
      hwm         <= hwm_next;
      pend_count  <= pend_count_next;
      drain_idx   <= drain_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    req_addr   <= req_addr_next;
    fresh      <= fresh_next;
    prod       <= prod_next;
    res_cpu    <= res_cpu_next;
    res_gpu    <= res_gpu_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cpu_address <= res_cpu;
      gpu_address <= res_gpu;
      slot_index  <= res_slot;
      status      <= res_status;
    end
  end

  a_pend_le_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pend_count <= alloc_count))
    else $error("pending frees exceed allocated count");

  a_alloc_le_hwm: assert property (@(posedge clk) disable iff (rst)
    alloc_count <= hwm)
    else $error("allocated count above stack watermark");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_FREE_DIV))
    else $error("divider finished outside a free");

  a_stack_wr_range: assert property (@(posedge clk) disable iff (rst)
    stack_we |-> (alloc_count != '0 && alloc_count <= hwm))
    else $error("stack write outside the allocated region");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("result overwrote an unaccepted beat");

endmodule
